// File: rtl/core/mvna_pkg.sv
package mvna_pkg;

    // Store geometry.
    localparam int NUM_VERTICES = 1024;
    localparam int IDX_W        = 10;
    localparam int ADDR_W       = $clog2(NUM_VERTICES);

    // Field widths.
    localparam int POS_W = 16;
    localparam int NRM_W = 16;
    localparam int SUM_W = 24;

    // Normalization datapath widths.
    localparam int DIF_W      = POS_W + 1;
    localparam int MUL_W      = 31;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CRS_W      = 35;
    localparam int MAG_W      = 34;
    localparam int A_W        = 30;
    localparam int SQ_W       = 62;
    localparam int ROOT_W     = 31;
    localparam int SQR_REM_W  = 32;
    localparam int FRAC_W     = 14;
    localparam int Q_W        = 15;
    localparam int NUM_W      = A_W + FRAC_W + 1;
    localparam int DREM_W     = ROOT_W;
    localparam int CNT_W      = 5;
    localparam int MAX_SHIFT  = 4;

    localparam int MUL_LAST   = 6;
    localparam int SQ_LAST    = 3;
    localparam int SQRT_LAST  = ROOT_W - 1;
    localparam int DIV_LAST   = Q_W - 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int RAM_W = 3 * SUM_W;

    // One normalized triangle waiting for the store update.
    typedef struct packed {
        logic [IDX_W-1:0]        idx0;
        logic [IDX_W-1:0]        idx1;
        logic [IDX_W-1:0]        idx2;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    degen;
    } tri_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_NORM,
        F_SQ,
        F_SQRT,
        F_DINIT,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CALC
    } back_state_t;

endpackage

// File: rtl/core/mvna_ram.sv
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mvna_front.sv
module mvna_front
    import mvna_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        idx0,
    input  logic [IDX_W-1:0]        idx1,
    input  logic [IDX_W-1:0]        idx2,
    input  logic signed [POS_W-1:0] v0_x,
    input  logic signed [POS_W-1:0] v0_y,
    input  logic signed [POS_W-1:0] v0_z,
    input  logic signed [POS_W-1:0] v1_x,
    input  logic signed [POS_W-1:0] v1_y,
    input  logic signed [POS_W-1:0] v1_z,
    input  logic signed [POS_W-1:0] v2_x,
    input  logic signed [POS_W-1:0] v2_y,
    input  logic signed [POS_W-1:0] v2_z,
    input  logic                    clearing,
    output logic                    push_valid,
    output tri_t                    push_data,
    input  logic                    push_full
);

    front_state_t state_reg, state_next;

    logic [CNT_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        idx_reg [3];
    logic signed [DIF_W-1:0] e1_reg [3];
    logic signed [DIF_W-1:0] e2_reg [3];
    logic signed [CRS_W-1:0] c_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic [A_W-1:0]          a_reg [3];
    logic                    neg_reg [3];
    logic [SQ_W-1:0]         sq_reg;
    logic [SQR_REM_W-1:0]    srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [DREM_W-1:0]       drem_reg [3];
    logic [Q_W-1:0]          dlow_reg [3];
    logic                    degen_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [MAG_W-1:0]         mag [3];
    logic [MAG_W-1:0]         mx;
    logic [2:0]               sh;
    logic                     all_zero;
    logic [CNT_W-1:0]         term;
    logic [SQ_W+1:0]          srem2;
    logic [SQ_W+1:0]          trial;
    logic [NUM_W-1:0]         num [3];
    logic [DREM_W:0]          r2 [3];
    logic                     accept;

    assign accept = in_valid && !in_stall;
    assign term   = cnt_reg - CNT_W'(1);

    // Shared multiplier: cross-product terms, then the three squares.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            F_MUL:
            begin
                case (cnt_reg)
                    CNT_W'(0): begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[2]); end
                    CNT_W'(1): begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[1]); end
                    CNT_W'(2): begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[0]); end
                    CNT_W'(3): begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[2]); end
                    CNT_W'(4): begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[1]); end
                    CNT_W'(5): begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[0]); end
                    default:   begin mul_a = '0; mul_b = '0; end
                endcase
            end
            F_SQ:
            begin
                case (cnt_reg)
                    CNT_W'(0): begin mul_a = $signed({1'b0, a_reg[0]}); mul_b = $signed({1'b0, a_reg[0]}); end
                    CNT_W'(1): begin mul_a = $signed({1'b0, a_reg[1]}); mul_b = $signed({1'b0, a_reg[1]}); end
                    CNT_W'(2): begin mul_a = $signed({1'b0, a_reg[2]}); mul_b = $signed({1'b0, a_reg[2]}); end
                    default:   begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Magnitudes and the shift that brings the largest below 2^30.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = MAG_W'(c_reg[i][CRS_W-1] ? -c_reg[i] : c_reg[i]);
        end
        mx = mag[0];
        if (mag[1] > mx)
        begin
            mx = mag[1];
        end
        if (mag[2] > mx)
        begin
            mx = mag[2];
        end
        sh = 3'(MAX_SHIFT);
        for (int s = MAX_SHIFT; s >= 0; s--)
        begin
            if ((mx >> s) < (MAG_W'(1) << A_W))
            begin
                sh = 3'(s);
            end
        end
        all_zero = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    end

    // Square root digit step and divider lanes.
    always_comb
    begin
        srem2 = (SQ_W+2)'({srem_reg, sq_reg[SQ_W-1:SQ_W-2]});
        trial = (SQ_W+2)'({root_reg, 2'b01});
        for (int i = 0; i < 3; i++)
        begin
            num[i] = NUM_W'({a_reg[i], {FRAC_W{1'b0}}}) + NUM_W'(root_reg >> 1);
            r2[i]  = {drem_reg[i], dlow_reg[i][Q_W-1]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_stall = clearing;
                if (in_valid && !clearing)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_LAST))
                begin
                    state_next = F_NORM;
                end
            end
            F_NORM:
            begin
                state_next = all_zero ? F_PUSH : F_SQ;
            end
            F_SQ:
            begin
                if (cnt_reg == CNT_W'(SQ_LAST))
                begin
                    state_next = F_SQRT;
                end
            end
            F_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_LAST))
                begin
                    state_next = F_DINIT;
                end
            end
            F_DINIT:
            begin
                state_next = (root_reg == '0) ? F_PUSH : F_DIV;
            end
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_LAST))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push_valid = !push_full;
                if (!push_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    idx_reg[0] <= idx0;
                    idx_reg[1] <= idx1;
                    idx_reg[2] <= idx2;
                    e1_reg[0]  <= DIF_W'(v1_x) - DIF_W'(v0_x);
                    e1_reg[1]  <= DIF_W'(v1_y) - DIF_W'(v0_y);
                    e1_reg[2]  <= DIF_W'(v1_z) - DIF_W'(v0_z);
                    e2_reg[0]  <= DIF_W'(v2_x) - DIF_W'(v0_x);
                    e2_reg[1]  <= DIF_W'(v2_y) - DIF_W'(v0_y);
                    e2_reg[2]  <= DIF_W'(v2_z) - DIF_W'(v0_z);
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i] <= '0;
                    end
                    degen_reg <= 1'b0;
                    cnt_reg   <= '0;
                end
            end
            F_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    if (term[0])
                    begin
                        c_reg[term[2:1]] <= c_reg[term[2:1]] - CRS_W'(prod_reg);
                    end
                    else
                    begin
                        c_reg[term[2:1]] <= c_reg[term[2:1]] + CRS_W'(prod_reg);
                    end
                end
                cnt_reg <= (cnt_reg == CNT_W'(MUL_LAST)) ? '0 : cnt_reg + CNT_W'(1);
            end
            F_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]   <= A_W'(mag[i] >> sh);
                    neg_reg[i] <= c_reg[i][CRS_W-1];
                end
                degen_reg <= all_zero;
                sq_reg    <= '0;
                cnt_reg   <= '0;
            end
            F_SQ:
            begin
                if (cnt_reg != '0)
                begin
                    sq_reg <= sq_reg + SQ_W'($unsigned(prod_reg));
                end
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= (cnt_reg == CNT_W'(SQ_LAST)) ? '0 : cnt_reg + CNT_W'(1);
            end
            F_SQRT:
            begin
                if (srem2 >= trial)
                begin
                    srem_reg <= SQR_REM_W'(srem2 - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= SQR_REM_W'(srem2);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                sq_reg  <= {sq_reg[SQ_W-3:0], 2'b00};
                cnt_reg <= (cnt_reg == CNT_W'(SQRT_LAST)) ? '0 : cnt_reg + CNT_W'(1);
            end
            F_DINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= DREM_W'(num[i] >> Q_W);
                    dlow_reg[i] <= num[i][Q_W-1:0];
                end
                if (root_reg == '0)
                begin
                    degen_reg <= 1'b1;
                end
                cnt_reg <= '0;
            end
            F_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (r2[i] >= {1'b0, root_reg})
                    begin
                        drem_reg[i] <= DREM_W'(r2[i] - {1'b0, root_reg});
                        dlow_reg[i] <= {dlow_reg[i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= DREM_W'(r2[i]);
                        dlow_reg[i] <= {dlow_reg[i][Q_W-2:0], 1'b0};
                    end
                end
                cnt_reg <= (cnt_reg == CNT_W'(DIV_LAST)) ? '0 : cnt_reg + CNT_W'(1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // After the divide the quotients sit in the low-part shift registers.
    always_comb
    begin
        push_data.idx0  = idx_reg[0];
        push_data.idx1  = idx_reg[1];
        push_data.idx2  = idx_reg[2];
        push_data.degen = degen_reg;
        if (degen_reg)
        begin
            push_data.nx = '0;
            push_data.ny = '0;
            push_data.nz = '0;
        end
        else
        begin
            push_data.nx = neg_reg[0] ? -NRM_W'(dlow_reg[0]) : NRM_W'(dlow_reg[0]);
            push_data.ny = neg_reg[1] ? -NRM_W'(dlow_reg[1]) : NRM_W'(dlow_reg[1]);
            push_data.nz = neg_reg[2] ? -NRM_W'(dlow_reg[2]) : NRM_W'(dlow_reg[2]);
        end
    end

endmodule

// File: rtl/core/mvna_queue.sv
module mvna_queue
    import mvna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tri_t push_data,
    output logic full,
    input  logic pop,
    output tri_t pop_data,
    output logic empty
);

    tri_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/mvna_back.sv
module mvna_back
    import mvna_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  tri_t                    q_data,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        vertex_index,
    output logic signed [SUM_W-1:0] sum_x,
    output logic signed [SUM_W-1:0] sum_y,
    output logic signed [SUM_W-1:0] sum_z,
    output logic signed [NRM_W-1:0] face_nx,
    output logic signed [NRM_W-1:0] face_ny,
    output logic signed [NRM_W-1:0] face_nz,
    output logic                    degenerate,
    output logic                    last
);

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [NRM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s > (SUM_W+1)'(SUM_MAX))
        begin
            return SUM_MAX;
        end
        else if (s < (SUM_W+1)'(SUM_MIN))
        begin
            return SUM_MIN;
        end
        return SUM_W'(s);
    endfunction

    back_state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    tri_t              tri_reg;
    logic [1:0]        k_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic signed [SUM_W-1:0] out_sx_reg, out_sy_reg, out_sz_reg;
    logic signed [NRM_W-1:0] out_nx_reg, out_ny_reg, out_nz_reg;
    logic              out_degen_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  cur_idx;
    logic              in_range;
    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;
    logic signed [SUM_W-1:0] new_x, new_y, new_z;
    logic              load_out;

    mvna_ram #(
        .WIDTH(RAM_W),
        .DEPTH(NUM_VERTICES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        case (k_reg)
            2'd0:    cur_idx = tri_reg.idx0;
            2'd1:    cur_idx = tri_reg.idx1;
            default: cur_idx = tri_reg.idx2;
        endcase
    end

    assign in_range = (32'(cur_idx) < NUM_VERTICES);
    assign out_free = !out_valid_reg || !out_stall;
    assign new_x    = sat_add($signed(ram_rdata[3*SUM_W-1:2*SUM_W]), tri_reg.nx);
    assign new_y    = sat_add($signed(ram_rdata[2*SUM_W-1:SUM_W]), tri_reg.ny);
    assign new_z    = sat_add($signed(ram_rdata[SUM_W-1:0]), tri_reg.nz);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = ADDR_W'(cur_idx);
        ram_wdata  = {new_x, new_y, new_z};
        load_out   = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
                if (32'(clr_cnt_reg) == NUM_VERTICES - 1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CALC;
            end
            B_CALC:
            begin
                if (out_free)
                begin
                    ram_we     = in_range;
                    load_out   = 1'b1;
                    state_next = (k_reg == 2'd2) ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (q_pop)
            begin
                k_reg <= 2'd0;
            end
            else if (load_out)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The face normal is captured with the sums so that a waiting result holds
    // steady while the next triangle is taken from the queue.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tri_reg <= q_data;
        end
        if (load_out)
        begin
            out_idx_reg   <= cur_idx;
            out_sx_reg    <= in_range ? new_x : '0;
            out_sy_reg    <= in_range ? new_y : '0;
            out_sz_reg    <= in_range ? new_z : '0;
            out_nx_reg    <= tri_reg.nx;
            out_ny_reg    <= tri_reg.ny;
            out_nz_reg    <= tri_reg.nz;
            out_degen_reg <= tri_reg.degen;
            out_last_reg  <= (k_reg == 2'd2);
        end
    end

    assign clearing     = (state_reg == B_CLEAR);
    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign sum_x        = out_sx_reg;
    assign sum_y        = out_sy_reg;
    assign sum_z        = out_sz_reg;
    assign face_nx      = out_nx_reg;
    assign face_ny      = out_ny_reg;
    assign face_nz      = out_nz_reg;
    assign degenerate   = out_degen_reg;
    assign last         = out_last_reg;

endmodule

// File: rtl/core/mesh_vertex_normal_accumulator.sv
// Smooth vertex normal accumulator. Each input item is one triangle: three
// vertex indices and three positions in signed Q8.8. The block forms the face
// normal as a cross product, scales it to unit length in Q1.14 and adds it,
// saturating, into a 1024-entry per-vertex sum store, once per vertex in the
// order idx0, idx1, idx2. Each triangle gives three result items, one per
// vertex, with that vertex's updated sum and the face normal; the third has
// last set. A zero-area triangle gives degenerate set and adds nothing.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. After reset the store is cleared one entry a cycle, and
// in_stall stays high for that time. In the front end the cross product and
// the squares run on one shared multiplier, followed by the bit-serial square
// root and the three parallel restoring dividers. The front end takes no new
// triangle until it has handed the last one to the queue. The back end reads
// and then writes the store for each vertex. A two-entry queue lets the front
// work on the next triangle while the back end waits on a stalled output
// register.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        idx0,
    input  logic [IDX_W-1:0]        idx1,
    input  logic [IDX_W-1:0]        idx2,
    input  logic signed [POS_W-1:0] v0_x,
    input  logic signed [POS_W-1:0] v0_y,
    input  logic signed [POS_W-1:0] v0_z,
    input  logic signed [POS_W-1:0] v1_x,
    input  logic signed [POS_W-1:0] v1_y,
    input  logic signed [POS_W-1:0] v1_z,
    input  logic signed [POS_W-1:0] v2_x,
    input  logic signed [POS_W-1:0] v2_y,
    input  logic signed [POS_W-1:0] v2_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        vertex_index,
    output logic signed [SUM_W-1:0] sum_x,
    output logic signed [SUM_W-1:0] sum_y,
    output logic signed [SUM_W-1:0] sum_z,
    output logic signed [NRM_W-1:0] face_nx,
    output logic signed [NRM_W-1:0] face_ny,
    output logic signed [NRM_W-1:0] face_nz,
    output logic                    degenerate,
    output logic                    last
);

    // Front to queue, queue to back.
    logic clearing;
    logic push;
    tri_t push_data;
    logic q_full;
    logic q_pop;
    tri_t q_data;
    logic q_empty;

    mvna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .idx0      (idx0),
        .idx1      (idx1),
        .idx2      (idx2),
        .v0_x      (v0_x),
        .v0_y      (v0_y),
        .v0_z      (v0_z),
        .v1_x      (v1_x),
        .v1_y      (v1_y),
        .v1_z      (v1_z),
        .v2_x      (v2_x),
        .v2_y      (v2_y),
        .v2_z      (v2_z),
        .clearing  (clearing),
        .push_valid(push),
        .push_data (push_data),
        .push_full (q_full)
    );

    // The queue decouples normalization from the store updates.
    mvna_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_data),
        .empty    (q_empty)
    );

    // The back end owns the store, its clearing pass and the output register.
    mvna_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vertex_index(vertex_index),
        .sum_x       (sum_x),
        .sum_y       (sum_y),
        .sum_z       (sum_z),
        .face_nx     (face_nx),
        .face_ny     (face_ny),
        .face_nz     (face_nz),
        .degenerate  (degenerate),
        .last        (last)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the smooth vertex normal accumulator.
//
// A triangle goes in, and three vertex items come out: one each for idx0, idx1 and idx2,
// in that order. The bench keeps its own copy of the per-vertex sum store.
// It also computes the face normal the same way the block does: an exact integer
// cross product, magnitude prescaling below 2^30, an integer square root and a
// divide that rounds half away from zero.
// Every item that the block accepts pushes three expected results onto a queue.
// Every result item that the block gives is popped against the oldest entry and
// compared field by field.
module tb_top;
    import mvna_pkg::*;

    localparam int STALL_LIMIT = 6000;   // covers the store clear after reset
    localparam int N_RANDOM    = 410;
    localparam int PILE_VTX    = 7;      // vertex hammered until its x sum saturates

    typedef struct {
        logic [IDX_W-1:0]        idx [3];
        logic signed [POS_W-1:0] pos [9];   // v0 xyz, v1 xyz, v2 xyz
        bit                      known;     // face normal typed into the row
        logic signed [NRM_W-1:0] kn  [3];
        bit                      kdegen;
    } triangle_t;

    typedef struct {
        logic [IDX_W-1:0]        vidx;
        logic signed [SUM_W-1:0] s   [3];
        logic signed [NRM_W-1:0] n   [3];
        bit                      degen;
        bit                      lst;
    } vertex_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [IDX_W-1:0]        idx0, idx1, idx2;
    logic signed [POS_W-1:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic                    out_valid;
    logic                    out_stall;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
    logic signed [NRM_W-1:0] face_nx, face_ny, face_nz;
    logic                    degenerate;
    logic                    last;

    // The bench's own copy of the accumulated normals, one row per vertex.
    longint         normal_store [3][NUM_VERTICES];
    vertex_result_t pending_vertices [$];
    triangle_t      directed_rows [$];
    int             n_errors;
    int             idle_cycles;
    bit             calm;      // when set, neither side inserts gaps

    mesh_vertex_normal_accumulator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .idx0         (idx0),
        .idx1         (idx1),
        .idx2         (idx2),
        .v0_x         (v0_x),
        .v0_y         (v0_y),
        .v0_z         (v0_z),
        .v1_x         (v1_x),
        .v1_y         (v1_y),
        .v1_z         (v1_z),
        .v2_x         (v2_x),
        .v2_y         (v2_y),
        .v2_z         (v2_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .sum_z        (sum_z),
        .face_nx      (face_nx),
        .face_ny      (face_ny),
        .face_nz      (face_nz),
        .degenerate   (degenerate),
        .last         (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Integer square root, floor, by the usual bit-pair method.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Unit face normal in Q1.14. A zero cross product sets the degenerate flag
    // and gives a zero normal.
    task automatic face_normal(input triangle_t t, output logic signed [NRM_W-1:0] n [3],
                               output bit degen);
        longint          e1 [3];
        longint          e2 [3];
        longint          c  [3];
        longint unsigned a  [3];
        longint unsigned peak, sq, len, q;
        int              sh;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(t.pos[3 + i]) - longint'(t.pos[i]);
            e2[i] = longint'(t.pos[6 + i]) - longint'(t.pos[i]);
            n[i]  = '0;
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        degen = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        if (!degen)
        begin
            peak = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
                if (a[i] > peak)
                    peak = a[i];
            end
            sh = 0;
            while ((peak >> sh) >= (64'd1 << 30))
                sh++;
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] >>= sh;
                sq += a[i] * a[i];
            end
            len = int_sqrt(sq);
            if (len == 0)
                degen = 1'b1;
            else
                for (int i = 0; i < 3; i++)
                begin
                    q    = (a[i] * 16384 + len / 2) / len;
                    n[i] = (c[i] < 0) ? -NRM_W'(q) : NRM_W'(q);
                end
        end
    endtask

    // Adds the face normal into the store for each vertex in turn and queues
    // the three vertex items that the triangle should produce.
    task automatic accumulate_triangle(input triangle_t t);
        logic signed [NRM_W-1:0] n [3];
        bit                      degen;
        vertex_result_t          r;
        longint                  s;
        face_normal(t, n, degen);
        if (t.known)
        begin
            n     = t.kn;
            degen = t.kdegen;
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s = normal_store[i][t.idx[k]] + longint'(n[i]);
                if (s > 8388607)
                    s = 8388607;
                if (s < -8388608)
                    s = -8388608;
                normal_store[i][t.idx[k]] = s;
                r.s[i] = SUM_W'(s);
            end
            r.vidx  = t.idx[k];
            r.n     = n;
            r.degen = degen;
            r.lst   = (k == 2);
            pending_vertices.push_back(r);
        end
    endtask

    function automatic triangle_t make_triangle(input int i0, i1, i2,
                                                input int ax, ay, az, bx, by, bz,
                                                input int cx, cy, cz);
        triangle_t t;
        t.idx = '{IDX_W'(i0), IDX_W'(i1), IDX_W'(i2)};
        t.pos = '{POS_W'(ax), POS_W'(ay), POS_W'(az), POS_W'(bx), POS_W'(by), POS_W'(bz),
                  POS_W'(cx), POS_W'(cy), POS_W'(cz)};
        t.known  = 1'b0;
        t.kn     = '{16'sd0, 16'sd0, 16'sd0};
        t.kdegen = 1'b0;
        return t;
    endfunction

    function automatic triangle_t with_normal(input triangle_t t, input int nx, ny, nz,
                                              input bit dg);
        t.known  = 1'b1;
        t.kn     = '{NRM_W'(nx), NRM_W'(ny), NRM_W'(nz)};
        t.kdegen = dg;
        return t;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drives one triangle and holds it until the block takes it.
    task automatic send_triangle(input triangle_t t);
        int gap;
        in_valid <= 1'b1;
        idx0 <= t.idx[0];
        idx1 <= t.idx[1];
        idx2 <= t.idx[2];
        v0_x <= t.pos[0];
        v0_y <= t.pos[1];
        v0_z <= t.pos[2];
        v1_x <= t.pos[3];
        v1_y <= t.pos[4];
        v1_z <= t.pos[5];
        v2_x <= t.pos[6];
        v2_y <= t.pos[7];
        v2_z <= t.pos[8];
        do
            @(posedge clk);
        while (in_stall);
        accumulate_triangle(t);
        gap = gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random triangle of one of four kinds: anywhere in the full coordinate range,
    // small and close together, zero area, or a pile-up on one vertex with a +x normal.
    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind, a, b;
        kind = $urandom_range(0, 99);
        t = make_triangle($urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 9; i++)
            t.pos[i] = POS_W'($urandom());
        if (kind < 25)
        begin
            // Full-range positions are already in place.
        end
        else if (kind < 40)
        begin
            for (int i = 0; i < 9; i++)
                t.pos[i] = POS_W'($urandom_range(0, 63)) - 16'sd32;
            t.idx[1] = IDX_W'($urandom_range(0, 15));
        end
        else if (kind < 50)
        begin
            // Zero area: all points equal, or the third point on the line from v0 to v1.
            a = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++)
            begin
                t.pos[i]     = POS_W'($urandom_range(0, 4000)) - 16'sd2000;
                t.pos[3 + i] = t.pos[i] + POS_W'($urandom_range(0, 20)) - 16'sd10;
                t.pos[6 + i] = t.pos[i] + (t.pos[3 + i] - t.pos[i]) * POS_W'(a);
            end
        end
        else
        begin
            a = $urandom_range(1, 300);
            b = $urandom_range(1, 300);
            t.idx = '{IDX_W'(PILE_VTX), IDX_W'(PILE_VTX), IDX_W'(PILE_VTX)};
            if ($urandom_range(0, 3) == 0)
                t.idx[$urandom_range(0, 2)] = IDX_W'($urandom_range(0, 1023));
            for (int i = 0; i < 3; i++)
            begin
                t.pos[i]     = POS_W'($urandom_range(0, 2000)) - 16'sd1000;
                t.pos[3 + i] = t.pos[i];
                t.pos[6 + i] = t.pos[i];
            end
            t.pos[4] = t.pos[1] + POS_W'(a);
            t.pos[8] = t.pos[2] + POS_W'(b);
        end
        return t;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result side: checks each item that the block hands over, then decides the next stall.
    always @(posedge clk)
    begin
        vertex_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex item, index %0d", $time, vertex_index);
                n_errors++;
            end
            else
            begin
                e = pending_vertices.pop_front();
                check_field("vertex_index", e.vidx, vertex_index);
                check_field("sum_x", e.s[0], sum_x);
                check_field("sum_y", e.s[1], sum_y);
                check_field("sum_z", e.s[2], sum_z);
                check_field("face_nx", e.n[0], face_nx);
                check_field("face_ny", e.n[1], face_ny);
                check_field("face_nz", e.n[2], face_nz);
                check_field("degenerate", e.degen, degenerate);
                check_field("last", e.lst, last);
            end
        end
        out_stall <= (gap_cycles() > 0) ? ($urandom_range(0, 99) < 70) : 1'b0;
    end

    // The watchdog ends the run when nothing has moved on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        idle_cycles = 0;
        n_errors    = 0;
        calm        = 1'b0;
        {idx0, idx1, idx2} = '0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
        for (int i = 0; i < 3; i++)
            for (int v = 0; v < NUM_VERTICES; v++)
                normal_store[i][v] = 0;

        // Directed rows. A typed normal appears only where it is plain from the geometry.
        // The first row comes straight out of reset: it has zero area, so every sum reads
        // back as zero.
        directed_rows.push_back(with_normal(make_triangle(0, 1023, 512, 0, 0, 0, 0, 0, 0,
                                            0, 0, 0), 0, 0, 0, 1'b1));
        // Unit triangles in the xy, yz and zx planes give the three axis normals.
        directed_rows.push_back(with_normal(make_triangle(1, 2, 3, 0, 0, 0, 256, 0, 0,
                                            0, 256, 0), 0, 0, 16384, 1'b0));
        directed_rows.push_back(with_normal(make_triangle(1, 2, 3, 0, 0, 0, 0, 256, 0,
                                            0, 0, 256), 16384, 0, 0, 1'b0));
        directed_rows.push_back(with_normal(make_triangle(1, 2, 3, 0, 0, 0, 0, 0, 256,
                                            256, 0, 0), 0, 16384, 0, 1'b0));
        // The same triangle with its winding reversed gives the opposite normal.
        directed_rows.push_back(with_normal(make_triangle(4, 5, 6, 0, 0, 0, 0, 256, 0,
                                            256, 0, 0), 0, 0, -16384, 1'b0));
        // Extreme coordinates give the largest cross product, which still points along +z.
        directed_rows.push_back(with_normal(make_triangle(1023, 0, 1023,
                                            -32768, -32768, 0, 32767, -32768, 0,
                                            -32768, 32767, 0), 0, 0, 16384, 1'b0));
        directed_rows.push_back(with_normal(make_triangle(1023, 1023, 1023,
                                            32767, 32767, 32767, -32768, 32767, 32767,
                                            32767, -32768, 32767), 0, 0, 16384, 1'b0));
        directed_rows.push_back(make_triangle(10, 11, 12, -32768, 32767, -32768,
                                              32767, -32768, 32767, 0, 0, -32768));
        directed_rows.push_back(make_triangle(13, 14, 15, 32767, 32767, 32767,
                                              -32768, -32768, -32768, -32768, 32767, 0));
        // Collinear points have zero area, even across the full coordinate range.
        directed_rows.push_back(with_normal(make_triangle(20, 21, 22, 0, 0, 0, 1, 1, 1,
                                            2, 2, 2), 0, 0, 0, 1'b1));
        directed_rows.push_back(with_normal(make_triangle(20, 21, 22, -32768, -32768, -32768,
                                            0, 0, 0, 32767, 32767, 32767), 0, 0, 0, 1'b1));
        // The smallest nonzero area, and a skewed normal.
        directed_rows.push_back(make_triangle(30, 31, 32, 5, 5, 5, 6, 5, 5, 5, 6, 5));
        directed_rows.push_back(make_triangle(30, 31, 32, 0, 0, 0, 3, 1, 7, -2, 5, 1));
        // A vertex named twice or three times gets the normal added once per mention.
        directed_rows.push_back(make_triangle(40, 40, 41, 0, 0, 0, 100, 0, 0, 0, 37, 91));
        directed_rows.push_back(make_triangle(42, 42, 42, 0, 0, 0, 0, 256, 0, 0, 0, 256));
        directed_rows.push_back(make_triangle(1023, 1023, 0, -7, 3, 0, 200, -90, 5,
                                              -300, 40, 1000));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_triangle(directed_rows[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_triangle(random_triangle());
        end
        in_valid <= 1'b0;

        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
